[rtl/core/deq_pkg.sv]
`timescale 1ns / 1ps

package deq_pkg;

  // Store geometry.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths of the stream payloads.
  localparam int VAL_W    = 32;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;
  localparam int OCC_W    = 5;
  localparam int S_DATA_W = ((VAL_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((VAL_W + OCC_W + 7) / 8) * 8;

  // Operation codes carried in the input tuser.
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;
  localparam logic [OP_W-1:0] OP_DUMP_FWD   = 3'd5;
  localparam logic [OP_W-1:0] OP_DUMP_BWD   = 3'd6;

  // Result status codes.
  localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [ST_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] STATUS_FULL  = 2'd2;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHIFT_IN_FRONT,
    CMD_LOAD_BACK,
    CMD_SHIFT_OUT_FRONT,
    CMD_ROT_FWD,
    CMD_ROT_BWD
  } cell_cmd_t;

  // Shared control that the top level drives into the chain.
  typedef struct packed {
    cell_cmd_t                cmd;
    logic [CNT_W-1:0]         count;
    logic signed [VAL_W-1:0]  value;
    logic signed [VAL_W-1:0]  head;
    logic signed [VAL_W-1:0]  tail;
  } cell_ctrl_t;

endpackage

[rtl/core/double_ended_queue_top.sv]
`timescale 1ns / 1ps

// Channel  Direction  tdata / tuser / tlast
// s_*      in         tdata[31:0] value; tuser[2:0] opcode
// m_*      out        tdata[31:0] result_value, [36:32] occupancy; tuser[1:0] status; tlast
//
// Push, pop and peek are single operations: a new transaction is accepted in every cycle while the
// result register drains. A dump walks the chain of cells, one result per cycle while the output
// does not stall, and no input is taken meanwhile.
// Reset is synchronous and clears the count, the dump walk state and the result valid flag.
// A stall on the output holds the result register, the dump walk and the input.

module double_ended_queue_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [deq_pkg::S_DATA_W-1:0]        s_tdata,   // value
  input  logic [deq_pkg::OP_W-1:0]            s_tuser,   // opcode
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [deq_pkg::M_DATA_W-1:0]        m_tdata,   // result_value, occupancy
  output logic [deq_pkg::ST_W-1:0]            m_tuser,   // status
  output logic                                m_tlast
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    STATE_IDLE = 2'b01,
    STATE_DUMP = 2'b10
  } state_t;

  state_t                  state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [CNT_W-1:0]        dump_k, dump_k_next;
  logic                    dump_fwd, dump_fwd_next;

  logic                    out_free;
  logic                    in_fire;
  logic [OP_W-1:0]         op;
  logic signed [VAL_W-1:0] in_value;
  logic                    full;
  logic                    empty;
  logic [IDX_W-1:0]        tail_idx;
  logic signed [VAL_W-1:0] head;
  logic signed [VAL_W-1:0] tail;

  logic                    load;
  logic signed [VAL_W-1:0] load_value;
  logic [ST_W-1:0]         load_status;
  logic                    load_last;

  logic signed [VAL_W-1:0] out_value;
  logic [ST_W-1:0]         out_status;
  logic                    out_last;
  logic [OCC_W-1:0]        out_occ;

  cell_cmd_t               cmd;
  cell_ctrl_t              ctrl;
  logic signed [VAL_W-1:0] cell_q [DEPTH];

  // Input handshake and field decode.
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == STATE_IDLE) && out_free;
  assign in_fire  = s_tvalid && s_tready;
  assign op       = s_tuser;
  assign in_value = signed'(s_tdata[VAL_W-1:0]);

  // Both ends of the live region.
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign tail_idx = IDX_W'(count - CNT_W'(1));
  assign head     = cell_q[0];
  assign tail     = cell_q[tail_idx];

  // Sequencing of single operations and dump walks.
  always_comb begin
    state_next    = state;
    count_next    = count;
    dump_k_next   = dump_k;
    dump_fwd_next = dump_fwd;
    load          = 1'b0;
    load_value    = '0;
    load_status   = STATUS_OK;
    load_last     = 1'b1;
    cmd           = CMD_HOLD;

    unique case (state)
      STATE_IDLE: begin
        if (in_fire) begin
          unique case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              load = 1'b1;
              if (full) begin
                load_status = STATUS_FULL;
              end else begin
                cmd        = (op == OP_PUSH_FRONT) ? CMD_SHIFT_IN_FRONT : CMD_LOAD_BACK;
                count_next = count + CNT_W'(1);
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK: begin
              load = 1'b1;
              if (empty) begin
                load_status = STATUS_EMPTY;
              end else begin
                load_value = (op == OP_POP_BACK) ? tail : head;
                if (op == OP_POP_FRONT) begin
                  cmd = CMD_SHIFT_OUT_FRONT;
                end
                if (op != OP_PEEK) begin
                  count_next = count - CNT_W'(1);
                end
              end
            end
            OP_DUMP_FWD, OP_DUMP_BWD: begin
              if (empty) begin
                load        = 1'b1;
                load_status = STATUS_EMPTY;
              end else begin
                state_next    = STATE_DUMP;
                dump_k_next   = '0;
                dump_fwd_next = (op == OP_DUMP_FWD);
              end
            end
            default: begin
              // The unused opcode is consumed without a result.
            end
          endcase
        end
      end
      STATE_DUMP: begin
        if (out_free) begin
          load        = 1'b1;
          load_value  = dump_fwd ? head : tail;
          load_last   = ((dump_k + CNT_W'(1)) == count);
          cmd         = dump_fwd ? CMD_ROT_FWD : CMD_ROT_BWD;
          dump_k_next = dump_k + CNT_W'(1);
          if (load_last) begin
            state_next = STATE_IDLE;
          end
        end
      end
      default: begin
        state_next = STATE_IDLE;
      end
    endcase
  end

  assign ctrl.cmd   = cmd;
  assign ctrl.count = count;
  assign ctrl.value = in_value;
  assign ctrl.head  = head;
  assign ctrl.tail  = tail;

  // Chain of element cells, each wired to its neighbors; the first takes the input value on its left.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] from_left;
    logic signed [VAL_W-1:0] from_right;

    if (i == 0) begin : g_first
      assign from_left = in_value;
    end else begin : g_inner_left
      assign from_left = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign from_right = cell_q[i];
    end else begin : g_inner_right
      assign from_right = cell_q[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (IDX_W'(i)),
      .from_left  (from_left),
      .from_right (from_right),
      .data       (cell_q[i])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= STATE_IDLE;
      count    <= '0;
      dump_k   <= '0;
      dump_fwd <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_k   <= dump_k_next;
      dump_fwd <= dump_fwd_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_value  <= load_value;
      out_status <= load_status;
      out_last   <= load_last;
      out_occ    <= OCC_W'(count_next);
    end
  end

  assign m_tdata = M_DATA_W'({out_occ, out_value});
  assign m_tuser = out_status;
  assign m_tlast = out_last;

endmodule

[rtl/core/deq_cell.sv]
`timescale 1ns / 1ps

module deq_cell (
  input  logic                             clk,
  input  deq_pkg::cell_ctrl_t              ctrl,
  input  logic [deq_pkg::IDX_W-1:0]        idx,
  input  logic signed [deq_pkg::VAL_W-1:0] from_left,
  input  logic signed [deq_pkg::VAL_W-1:0] from_right,
  output logic signed [deq_pkg::VAL_W-1:0] data
);
  import deq_pkg::*;

  logic [CNT_W-1:0]        pos;
  logic                    at_first;
  logic                    at_tail_slot;
  logic                    at_live_end;
  logic signed [VAL_W-1:0] data_next;

  // Position of this cell relative to the live region.
  assign pos          = CNT_W'(idx);
  assign at_first     = (idx == '0);
  assign at_tail_slot = (pos == ctrl.count);
  assign at_live_end  = ((pos + CNT_W'(1)) == ctrl.count);

  // Select what this cell holds after the cycle.
  always_comb begin
    data_next = data;
    unique case (ctrl.cmd)
      CMD_HOLD:            data_next = data;
      CMD_SHIFT_IN_FRONT:  data_next = at_first ? ctrl.value : from_left;
      CMD_LOAD_BACK:       data_next = at_tail_slot ? ctrl.value : data;
      CMD_SHIFT_OUT_FRONT: data_next = from_right;
      CMD_ROT_FWD:         data_next = at_live_end ? ctrl.head : from_right;
      CMD_ROT_BWD:         data_next = at_first ? ctrl.tail : from_left;
      default:             data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[verif/double_ended_queue_top_tb.sv]
`timescale 1ns / 1ps

module double_ended_queue_top_tb;
  import deq_pkg::*;

  // The block ignores this opcode: it gives no result and leaves the store alone.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  localparam int CMD_TARGET  = 360;
  localparam int STUCK_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 20;

  // One command for the input stream, with the idle time that follows it.
  typedef struct {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
    int                      gap;
  } deque_cmd_t;

  // One result that the block owes on the output stream.
  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [ST_W-1:0]         status;
    logic                    last;
    logic [OCC_W-1:0]        occupancy;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata  = '0;
  logic [OP_W-1:0]      s_tuser  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;
  logic [ST_W-1:0]      m_tuser;
  logic                 m_tlast;

  double_ended_queue_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Commands waiting to be driven, and results the block still owes.
  deque_cmd_t    deque_cmds[$];
  deque_result_t deque_results_due[$];

  // Shadow copy of the deque contents.
  logic signed [VAL_W-1:0] shadow_store [DEPTH];
  logic [IDX_W-1:0]        shadow_front = '0;
  logic [CNT_W-1:0]        shadow_count = '0;

  // Generation-side occupancy tracking and idle control.
  int gen_count    = 0;
  int gen_real     = 0;
  bit gen_no_idle  = 1'b0;

  // Run statistics.
  int error_count   = 0;
  int cmds_taken    = 0;
  int dumps_taken   = 0;
  int results_seen  = 0;
  int full_replies  = 0;
  int empty_replies = 0;
  int peak_fill     = 0;

  logic in_handshake = 1'b0;
  int   in_gap       = 0;
  int   out_hold     = 0;
  int   out_phase    = 0;
  bit   out_steady   = 1'b0;
  int   stuck_cycles = 0;

  function automatic logic [IDX_W-1:0] slot_of(input int offset);
    return IDX_W'(int'(shadow_front) + offset);
  endfunction

  function automatic void owe_result(input logic signed [VAL_W-1:0] v,
                                     input logic [ST_W-1:0] st, input logic lst);
    deque_result_t r;
    r.value     = v;
    r.status    = st;
    r.last      = lst;
    r.occupancy = OCC_W'(shadow_count);
    deque_results_due.push_back(r);
  endfunction

  // Apply one accepted command to the shadow deque and record what it must return.
  function automatic void predict_deque_op(input logic [OP_W-1:0] op,
                                           input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] got;
    int                      n;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count == CNT_W'(DEPTH)) begin
          owe_result('0, STATUS_FULL, 1'b1);
        end else begin
          if (op == OP_PUSH_FRONT) begin
            shadow_front = shadow_front - 1'b1;
            shadow_store[shadow_front] = v;
          end else begin
            shadow_store[slot_of(int'(shadow_count))] = v;
          end
          shadow_count = shadow_count + 1'b1;
          owe_result('0, STATUS_OK, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK: begin
        if (shadow_count == '0) begin
          owe_result('0, STATUS_EMPTY, 1'b1);
        end else if (op == OP_POP_BACK) begin
          got = shadow_store[slot_of(int'(shadow_count) - 1)];
          shadow_count = shadow_count - 1'b1;
          owe_result(got, STATUS_OK, 1'b1);
        end else begin
          got = shadow_store[shadow_front];
          if (op == OP_POP_FRONT) begin
            shadow_front = slot_of(1);
            shadow_count = shadow_count - 1'b1;
          end
          owe_result(got, STATUS_OK, 1'b1);
        end
      end
      OP_DUMP_FWD, OP_DUMP_BWD: begin
        n = int'(shadow_count);
        if (n == 0) begin
          owe_result('0, STATUS_EMPTY, 1'b1);
        end else begin
          for (int k = 0; k < n; k++) begin
            got = shadow_store[slot_of((op == OP_DUMP_FWD) ? k : n - 1 - k)];
            owe_result(got, STATUS_OK, k == n - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Idle stretches are mostly short, now and then much longer.
  function automatic int idle_len();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] rand_push();
    return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
  endfunction

  function automatic logic [OP_W-1:0] rand_pop();
    return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  // Queue one command and track the occupancy it will leave behind.
  function automatic void add_cmd(input logic [OP_W-1:0] op,
                                  input logic signed [VAL_W-1:0] v);
    deque_cmd_t c;
    c.op    = op;
    c.value = v;
    c.gap   = (gen_no_idle || $urandom_range(0, 1)) ? 0 : idle_len();
    deque_cmds.push_back(c);
    if (op != OP_UNUSED) gen_real++;
    if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && gen_count < DEPTH) gen_count++;
    if ((op == OP_POP_FRONT || op == OP_POP_BACK) && gen_count > 0) gen_count--;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Input driver: present the next command once the previous transaction and its gap are done.
  always @(negedge clk) begin
    deque_cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_handshake) begin
      if (in_gap > 0) begin
        s_tvalid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (deque_cmds.size() > 0) begin
        c = deque_cmds.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= c.value;
        s_tuser  <= c.op;
        in_gap = c.gap;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output back-pressure: random stalls, with stretches where the sink never stalls.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_phase == 0) begin
        out_steady = ($urandom_range(0, 3) == 0);
        out_phase  = $urandom_range(50, 300);
      end
      out_phase = out_phase - 1;
      if (out_hold == 0 && !out_steady && $urandom_range(0, 3) == 0) out_hold = idle_len();
      if (out_hold > 0) begin
        m_tready <= 1'b0;
        out_hold = out_hold - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Predict on each accepted command, then check each accepted result against the oldest owed.
  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      in_handshake <= 1'b0;
    end else begin
      in_handshake <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        predict_deque_op(s_tuser, s_tdata[VAL_W-1:0]);
        if (s_tuser != OP_UNUSED) cmds_taken++;
        if (s_tuser == OP_DUMP_FWD || s_tuser == OP_DUMP_BWD) dumps_taken++;
        if (int'(shadow_count) > peak_fill) peak_fill = int'(shadow_count);
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (deque_results_due.size() == 0) begin
          $error("unexpected result: value %0h status %0d", m_tdata[VAL_W-1:0], m_tuser);
          error_count++;
        end else begin
          want = deque_results_due.pop_front();
          check_field("result_value", want.value, m_tdata[VAL_W-1:0]);
          check_field("status", want.status, m_tuser);
          check_field("last", want.last, m_tlast);
          check_field("occupancy", want.occupancy, m_tdata[VAL_W +: OCC_W]);
          if (want.status == STATUS_FULL) full_replies++;
          if (want.status == STATUS_EMPTY) empty_replies++;
        end
      end
    end
  end

  // Watchdog: the run is stuck if no transaction happens on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("double_ended_queue_top verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int         n;
    int         phase;
    int         r;
    logic [OP_W-1:0] op;

    // Directed part: empty replies, extremes at both ends, dumps both ways, the unused opcode.
    add_cmd(OP_POP_FRONT, 32'sd5);
    add_cmd(OP_POP_BACK, 32'sd6);
    add_cmd(OP_PEEK, '1);
    add_cmd(OP_DUMP_FWD, '0);
    add_cmd(OP_DUMP_BWD, '0);
    add_cmd(OP_UNUSED, 32'sh1234_5678);
    add_cmd(OP_PUSH_BACK, 32'sh7FFF_FFFF);
    add_cmd(OP_PUSH_FRONT, 32'sh8000_0000);
    add_cmd(OP_PUSH_BACK, '0);
    add_cmd(OP_PUSH_FRONT, '1);
    add_cmd(OP_PEEK, '0);
    add_cmd(OP_DUMP_FWD, '0);
    add_cmd(OP_DUMP_BWD, '0);
    add_cmd(OP_POP_BACK, '0);
    add_cmd(OP_POP_FRONT, '0);
    add_cmd(OP_UNUSED, '1);
    add_cmd(OP_DUMP_FWD, '0);
    add_cmd(OP_POP_FRONT, '0);
    add_cmd(OP_POP_BACK, '0);
    add_cmd(OP_POP_BACK, '0);

    // Random part in phases: fill to the top and beyond, drain to empty and beyond, or mix.
    while (gen_real < CMD_TARGET) begin
      phase       = $urandom_range(0, 2);
      gen_no_idle = ($urandom_range(0, 4) == 0);
      n           = $urandom_range(15, 45);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 3)                op = OP_UNUSED;
        else if (r < 11)          op = $urandom_range(0, 1) ? OP_DUMP_BWD : OP_DUMP_FWD;
        else if (r < 17)          op = OP_PEEK;
        else if (phase == 0)      op = (r < 87) ? rand_push() : rand_pop();
        else if (phase == 1)      op = (r < 87) ? rand_pop() : rand_push();
        else                      op = (r < 58) ? rand_push() : rand_pop();
        add_cmd(op, rand_value());
      end
      if (phase == 0) begin
        while (gen_count < DEPTH) add_cmd(rand_push(), rand_value());
        repeat ($urandom_range(1, 3)) add_cmd(rand_push(), rand_value());
      end else if (phase == 1) begin
        while (gen_count > 0) add_cmd(rand_pop(), rand_value());
        add_cmd($urandom_range(0, 1) ? OP_PEEK : rand_pop(), rand_value());
      end
    end
    gen_no_idle = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait for all commands to go in and all owed results to come out.
    while (deque_cmds.size() > 0 || s_tvalid || deque_results_due.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d commands including %0d dumps; checked %0d results.",
             cmds_taken, dumps_taken, results_seen);
    $display("Saw %0d full refusals, %0d empty replies, peak fill %0d of %0d.",
             full_replies, empty_replies, peak_fill, DEPTH);
    if (error_count == 0) begin
      $display("double_ended_queue_top verification clean");
    end else begin
      $display("double_ended_queue_top verification failed");
    end
    $finish;
  end

endmodule
